// File: rtl/csmv_pkg.sv
// Shared types and constants for the COO sparse matrix-vector multiplier.
// Used by every module of the block; depends on nothing.
package csmv_pkg;

  localparam int unsigned VECTOR_LEN = 1024;
  localparam int unsigned VEC_AW     = $clog2(VECTOR_LEN);

  localparam int unsigned COL_W  = 10;
  localparam int unsigned ROW_W  = 10;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned SUM_W  = 42;

  localparam int unsigned IN_DATA_W  = ((COL_W + ROW_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((ROW_W + SUM_W + 7) / 8) * 8;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned ODEPTH = 4;
  localparam int unsigned OAW    = $clog2(ODEPTH);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ENTRY = 1'b1
  } op_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] elem;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [SUM_W-1:0] sum;
    logic             final_res;
  } result_t;

endpackage

// File: rtl/csmv_front.sv
// Front end: accepts transactions, writes vector loads into the vector memory and
// looks up the vector element of each matrix entry. Depends on csmv_pkg.
module csmv_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  csmv_pkg::op_t                     in_op,
  input  logic [csmv_pkg::COL_W-1:0]        in_column,
  input  logic [csmv_pkg::ROW_W-1:0]        in_row,
  input  logic [csmv_pkg::VAL_W-1:0]        in_value,
  input  logic                              in_last,
  output logic                              ent_valid,
  input  logic                              ent_ready,
  output csmv_pkg::entry_t                  ent
);

  logic [csmv_pkg::VAL_W-1:0] vec_mem [csmv_pkg::VECTOR_LEN];
  logic [csmv_pkg::VAL_W-1:0] rd_data_r;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [csmv_pkg::ROW_W-1:0]  s1_row_r;
  logic [csmv_pkg::VAL_W-1:0]  s1_value_r;
  logic                        s1_last_r;
  logic                        s1_col_ok_r;

  logic                        accept;
  logic                        col_ok;
  logic [csmv_pkg::VEC_AW-1:0] addr;

  assign in_ready = !s1_valid_r || ent_ready;
  assign accept   = in_valid && in_ready;
  assign col_ok   = 32'(in_column) < 32'(csmv_pkg::VECTOR_LEN);
  assign addr     = csmv_pkg::VEC_AW'(in_column);

  // Write and lookup both happen at the accept edge, so an entry that directly
  // follows a load of its column sees the new element.
  always_ff @(posedge clk) begin
    if (accept && in_op == csmv_pkg::OP_LOAD && col_ok) begin
      vec_mem[addr] <= in_value;
    end
    if (accept && in_op == csmv_pkg::OP_ENTRY) begin
      rd_data_r <= vec_mem[addr];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = (in_op == csmv_pkg::OP_ENTRY);
    end else if (ent_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_op == csmv_pkg::OP_ENTRY) begin
      s1_row_r    <= in_row;
      s1_value_r  <= in_value;
      s1_last_r   <= in_last;
      s1_col_ok_r <= col_ok;
    end
  end

  assign ent_valid = s1_valid_r;
  assign ent.row   = s1_row_r;
  assign ent.value = s1_value_r;
  assign ent.elem  = s1_col_ok_r ? rd_data_r : '0;
  assign ent.last  = s1_last_r;

endmodule

// File: rtl/csmv_entry_q.sv
// Short queue of looked-up matrix entries between the front end and the back end.
// Depends on csmv_pkg.
module csmv_entry_q (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  csmv_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output csmv_pkg::entry_t pop_data
);

  csmv_pkg::entry_t            slots_r [csmv_pkg::QDEPTH];
  logic [csmv_pkg::QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [csmv_pkg::QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [csmv_pkg::QAW:0]      cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign push_ready = cnt_r != (csmv_pkg::QAW+1)'(csmv_pkg::QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (csmv_pkg::QAW+1)'(do_push) - (csmv_pkg::QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/csmv_back.sv
// Back end: multiplies each entry by its vector element, accumulates row sums and
// queues finished rows for the result channel. Depends on csmv_pkg.
module csmv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ent_valid,
  output logic              ent_ready,
  input  csmv_pkg::entry_t  ent,
  output logic              res_valid,
  input  logic              res_ready,
  output csmv_pkg::result_t res
);

  // Multiply stage.
  logic                              m_valid_r, m_valid_nxt;
  logic signed [csmv_pkg::PROD_W-1:0] m_prod_r;
  logic [csmv_pkg::ROW_W-1:0]        m_row_r;
  logic                              m_last_r;

  // Row accumulator.
  logic                       open_r, open_nxt;
  logic [csmv_pkg::ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [csmv_pkg::SUM_W-1:0] sum_r, sum_nxt;

  // Result queue; one accumulate can add two results.
  csmv_pkg::result_t          ofifo_r [csmv_pkg::ODEPTH];
  logic [csmv_pkg::OAW-1:0]   owr_ptr_r, owr_ptr_nxt;
  logic [csmv_pkg::OAW-1:0]   ord_ptr_r, ord_ptr_nxt;
  logic [csmv_pkg::OAW:0]     ocnt_r, ocnt_nxt;

  logic                       acc_fire, row_change, push0, push1, do_pop;
  logic [csmv_pkg::SUM_W-1:0] prod_ext, base, nsum;
  logic [csmv_pkg::OAW:0]     npush;
  csmv_pkg::result_t          r0, r1;

  assign acc_fire  = m_valid_r &&
                     (ocnt_r <= (csmv_pkg::OAW+1)'(csmv_pkg::ODEPTH - 2));
  assign ent_ready = !m_valid_r || acc_fire;

  always_comb begin
    m_valid_nxt = m_valid_r;
    if (ent_ready) begin
      m_valid_nxt = ent_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_ready && ent_valid) begin
      m_prod_r <= $signed(ent.value) * $signed(ent.elem);
      m_row_r  <= ent.row;
      m_last_r <= ent.last;
    end
  end

  assign prod_ext   = {{(csmv_pkg::SUM_W - csmv_pkg::PROD_W){m_prod_r[csmv_pkg::PROD_W-1]}},
                       m_prod_r};
  assign row_change = open_r && (m_row_r != cur_row_r);
  assign base       = row_change ? '0 : sum_r;
  assign nsum       = base + prod_ext;
  assign push0      = acc_fire && row_change;
  assign push1      = acc_fire && m_last_r;

  always_comb begin
    r0.row_index = cur_row_r;
    r0.sum       = sum_r;
    r0.final_res = 1'b0;
    r1.row_index = m_row_r;
    r1.sum       = nsum;
    r1.final_res = 1'b1;
  end

  always_comb begin
    open_nxt    = open_r;
    cur_row_nxt = cur_row_r;
    sum_nxt     = sum_r;
    if (acc_fire) begin
      cur_row_nxt = m_row_r;
      if (m_last_r) begin
        open_nxt = 1'b0;
        sum_nxt  = '0;
      end else begin
        open_nxt = 1'b1;
        sum_nxt  = nsum;
      end
    end
  end

  assign do_pop = res_valid && res_ready;
  assign npush  = (csmv_pkg::OAW+1)'(push0) + (csmv_pkg::OAW+1)'(push1);

  always_comb begin
    owr_ptr_nxt = owr_ptr_r + csmv_pkg::OAW'(npush);
    ord_ptr_nxt = do_pop ? ord_ptr_r + 1'b1 : ord_ptr_r;
    ocnt_nxt    = ocnt_r + npush - (csmv_pkg::OAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      open_r    <= 1'b0;
      cur_row_r <= '0;
      sum_r     <= '0;
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      m_valid_r <= m_valid_nxt;
      open_r    <= open_nxt;
      cur_row_r <= cur_row_nxt;
      sum_r     <= sum_nxt;
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  // The closed previous row goes first, then the row ended by the last entry.
  always_ff @(posedge clk) begin
    if (push0) begin
      ofifo_r[owr_ptr_r] <= r0;
    end
    if (push1) begin
      ofifo_r[push0 ? owr_ptr_r + 1'b1 : owr_ptr_r] <= r1;
    end
  end

  assign res_valid = ocnt_r != '0;
  assign res       = ofifo_r[ord_ptr_r];

endmodule

// File: rtl/coo_sparse_matrix_vector_multiply.sv
// COO sparse matrix times dense vector, signed Q1.15 inputs, exact 42-bit row sums.
// Throughput: one transaction per cycle while the result channel keeps up; a matrix
// entry that closes a row and is also last adds two results, which the result queue absorbs.
// Path: a result passes the front stage, entry queue, multiply stage and result queue registers.
// Reset: synchronous active-low rst_n clears all control state and any open row;
// the vector memory is not cleared and must be loaded before it is used.
module coo_sparse_matrix_vector_multiply (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [csmv_pkg::IN_DATA_W-1:0]      in_tdata,  // column, row, value, zero pad
  input  logic                                in_tuser,  // op
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [csmv_pkg::OUT_DATA_W-1:0]     out_tdata, // row_index, sum, zero pad
  output logic                                out_tlast
);

  localparam int unsigned ROW_LSB = csmv_pkg::COL_W;
  localparam int unsigned VAL_LSB = csmv_pkg::COL_W + csmv_pkg::ROW_W;
  localparam int unsigned OPAD_W  = csmv_pkg::OUT_DATA_W - csmv_pkg::ROW_W - csmv_pkg::SUM_W;

  logic              f_valid, f_ready, b_valid, b_ready;
  csmv_pkg::entry_t  f_ent, b_ent;
  csmv_pkg::result_t res;
  csmv_pkg::op_t     in_op;

  assign in_op = csmv_pkg::op_t'(in_tuser);

  csmv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_op),
    .in_column (in_tdata[csmv_pkg::COL_W-1:0]),
    .in_row    (in_tdata[ROW_LSB +: csmv_pkg::ROW_W]),
    .in_value  (in_tdata[VAL_LSB +: csmv_pkg::VAL_W]),
    .in_last   (in_tlast),
    .ent_valid (f_valid),
    .ent_ready (f_ready),
    .ent       (f_ent)
  );

  csmv_entry_q u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_ent),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_ent)
  );

  csmv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (b_valid),
    .ent_ready (b_ready),
    .ent       (b_ent),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{OPAD_W{1'b0}}, res.sum, res.row_index};
  assign out_tlast = res.final_res;

endmodule

// File: rtl/csmv_checker.sv
// Port-level checker for coo_sparse_matrix_vector_multiply, bound to the top level.
// Depends on csmv_pkg for the port widths.
module csmv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [csmv_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [csmv_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // A result cannot appear without an input transaction in the cycles before it.
  a_no_spurious: assert property (@(posedge clk)
    !rst_n ##1 !(in_tvalid && in_tready) ##1 !(in_tvalid && in_tready)
      ##1 !(in_tvalid && in_tready) |-> !out_tvalid)
    else $error("result appeared without input");

endmodule

bind coo_sparse_matrix_vector_multiply csmv_checker u_csmv_checker (.*);
